// ----- hdl/life_automaton_torus_step_core_assert.svh -----
// assertion macros for the life automaton core
`ifndef LIFE_AUTOMATON_TORUS_STEP_CORE_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_STEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LAT_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// next-cycle implication
`define LAT_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define LAT_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons)
`define LAT_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)
`endif
`endif

// ----- hdl/lat_pkg.sv -----
package lat_pkg;

    localparam int ROW_W     = 64;
    localparam int CMD_W     = 2;
    localparam int ROW_NUM_W = 6;
    localparam int SIZE_W    = 7;

    localparam int MAX_SIDE_DEFAULT = 64;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] MIN_SIDE        = 7'd3;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_STEP = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_FIRST,
        ST_STEP_LAST,
        ST_STEP_ROW,
        ST_FINISH
    } state_t;

    // read address source
    typedef enum logic [1:0] {
        RD_ITEM,
        RD_LAST,
        RD_ONE,
        RD_AHEAD
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    first_cap;
        logic    last_cap;
        logic    row_write;
        logic    result_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic item_step;
        logic row_last;
        logic out_free;
    } dp_status_t;

    // one generation of one row, all columns in parallel, torus wrap at last_col
    function automatic logic [ROW_W-1:0] next_row(
        input logic [ROW_W-1:0]     up,
        input logic [ROW_W-1:0]     mid,
        input logic [ROW_W-1:0]     down,
        input logic [ROW_NUM_W-1:0] last_col,
        input logic [ROW_W-1:0]     mask
    );
        logic [ROW_W-1:0]     res;
        logic [ROW_NUM_W-1:0] w;
        logic [ROW_NUM_W-1:0] e;
        logic [3:0]           cnt;
        res = '0;
        for (int j = 0; j < ROW_W; j++)
        begin
            w = (j == 0) ? last_col : ROW_NUM_W'(j - 1);
            e = (ROW_NUM_W'(j) == last_col) ? '0 : ROW_NUM_W'(j + 1);
            cnt = {3'b000, up[w]}   + {3'b000, up[j]}   + {3'b000, up[e]}
                + {3'b000, mid[w]}                      + {3'b000, mid[e]}
                + {3'b000, down[w]} + {3'b000, down[j]} + {3'b000, down[e]};
            res[j] = mask[j] & ((cnt == BIRTH_COUNT) || (mid[j] && (cnt == SURVIVE_COUNT)));
        end
        return res;
    endfunction

endpackage

// ----- hdl/lat_req_if.sv -----
interface lat_req_if;
    import lat_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [ROW_NUM_W-1:0] row_number;
    logic [ROW_W-1:0]     row_cells;

    modport source (output valid, output command, output row_number, output row_cells,
                    input ready);
    modport sink   (input valid, input command, input row_number, input row_cells,
                    output ready);
endinterface

// ----- hdl/lat_rsp_if.sv -----
interface lat_rsp_if;
    import lat_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_value;
    logic             status;

    modport source (output valid, output row_value, output status, input ready);
    modport sink   (input valid, input row_value, input status, output ready);
endinterface

// ----- hdl/lat_ctrl.sv -----
module lat_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lat_pkg::dp_status_t  dp_status,
    output lat_pkg::ctl_cmd_t    ctl
);
    import lat_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = RD_ITEM;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    ctl.rd_en  = 1'b1;
                    state_next = dp_status.item_step ? ST_STEP_FIRST : ST_FINISH;
                end
            end
            ST_STEP_FIRST:
            begin
                ctl.first_cap = 1'b1;
                ctl.rd_en     = 1'b1;
                ctl.rd_sel    = RD_LAST;
                state_next    = ST_STEP_LAST;
            end
            ST_STEP_LAST:
            begin
                ctl.last_cap = 1'b1;
                ctl.rd_en    = 1'b1;
                ctl.rd_sel   = RD_ONE;
                state_next   = ST_STEP_ROW;
            end
            ST_STEP_ROW:
            begin
                ctl.row_write = 1'b1;
                ctl.rd_en     = 1'b1;
                ctl.rd_sel    = RD_AHEAD;
                if (dp_status.row_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- hdl/lat_dpath.sv -----
module lat_dpath #(
    parameter int MAX_SIDE = lat_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lat_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  logic [lat_pkg::CMD_W-1:0]     in_command,
    input  logic [lat_pkg::ROW_NUM_W-1:0] in_row_number,
    input  logic [lat_pkg::ROW_W-1:0]     in_row_cells,
    input  lat_pkg::ctl_cmd_t             ctl,
    output lat_pkg::dp_status_t           dp_status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lat_pkg::ROW_W-1:0]     out_row_value,
    output logic                          out_status
);
    import lat_pkg::*;

    localparam int                AW         = $clog2(MAX_SIDE);
    localparam logic [SIZE_W-1:0] MAX_SIDE_W = SIZE_W'(MAX_SIDE);

    logic [SIZE_W-1:0]    grid_size_reg;
    logic [SIZE_W-1:0]    side;
    logic [SIZE_W-1:0]    side_m1;
    logic [ROW_NUM_W-1:0] last_col;
    logic [ROW_W-1:0]     mask;
    logic                 in_range;

    logic [CMD_W-1:0]     cmd_reg;
    logic                 oob_reg;

    logic [ROW_W-1:0]     mem [MAX_SIDE];
    logic [MAX_SIDE-1:0]  valid_reg;
    logic [ROW_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;
    logic [ROW_W-1:0]     rd_word;
    logic [AW-1:0]        rd_addr;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ROW_W-1:0]     wr_data;

    logic [ROW_W-1:0]     first_reg;
    logic [ROW_W-1:0]     prev_reg;
    logic [ROW_W-1:0]     mid_reg;
    logic [ROW_W-1:0]     down;
    logic [AW-1:0]        r_reg;
    logic                 row_last;

    logic                 out_valid_reg;
    logic [ROW_W-1:0]     out_value_reg;
    logic                 out_status_reg;
    logic [ROW_W-1:0]     out_value_next;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            grid_size_reg <= cfg_wr_data;
        end
    end

    // side in use, clamped to the legal range
    always_comb
    begin
        priority if (grid_size_reg < MIN_SIDE)
        begin
            side = MIN_SIDE;
        end
        else if (grid_size_reg > MAX_SIDE_W)
        begin
            side = MAX_SIDE_W;
        end
        else
        begin
            side = grid_size_reg;
        end
    end

    assign side_m1  = side - SIZE_W'(1);
    assign last_col = side_m1[ROW_NUM_W-1:0];
    assign in_range = {1'b0, in_row_number} < side;

    // column mask
    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            mask[j] = SIZE_W'(j) < side;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= in_command;
            oob_reg <= ((in_command == CMD_LOAD) || (in_command == CMD_READ)) && !in_range;
        end
    end

    // read address
    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_ITEM:  rd_addr = (in_command == CMD_STEP) ? '0 : in_row_number[AW-1:0];
            RD_LAST:  rd_addr = side_m1[AW-1:0];
            RD_ONE:   rd_addr = AW'(1);
            RD_AHEAD: rd_addr = r_reg + AW'(2);
            default:  rd_addr = '0;
        endcase
    end

    // row pipeline around the current row
    assign rd_word  = rd_valid_reg ? (rd_data_reg & mask) : '0;
    assign row_last = {{(SIZE_W-AW){1'b0}}, r_reg} == side_m1;
    assign down     = row_last ? first_reg : rd_word;

    // write port: load from item or rewrite during a generation
    assign wr_en   = (ctl.accept && (in_command == CMD_LOAD) && in_range) || ctl.row_write;
    assign wr_addr = ctl.row_write ? r_reg : in_row_number[AW-1:0];
    assign wr_data = ctl.row_write ? next_row(prev_reg, mid_reg, down, last_col, mask)
                                   : (in_row_cells & mask);

    // grid memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // row valid bits, unwritten rows read as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // sliding rows of the generation
    always_ff @(posedge clk)
    begin
        if (ctl.first_cap)
        begin
            first_reg <= rd_word;
            mid_reg   <= rd_word;
        end
        if (ctl.last_cap)
        begin
            prev_reg <= rd_word;
        end
        if (ctl.row_write)
        begin
            prev_reg <= mid_reg;
            mid_reg  <= down;
        end
    end

    // row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
        end
        else if (ctl.first_cap)
        begin
            r_reg <= '0;
        end
        else if (ctl.row_write)
        begin
            r_reg <= r_reg + AW'(1);
        end
    end

    // result register
    assign out_value_next = ((cmd_reg == CMD_READ) && !oob_reg) ? rd_word : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.result_load)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= oob_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row_value = out_value_reg;
    assign out_status    = out_status_reg;

    // status to the controller
    assign dp_status.item_step = in_command == CMD_STEP;
    assign dp_status.row_last  = row_last;
    assign dp_status.out_free  = !out_valid_reg || out_ready;
endmodule

// ----- hdl/life_automaton_torus_step_core.sv -----
// Life automaton on a square torus of one-bit cells, one row per memory word.
// The request channel carries command, row_number and row_cells; the response
// channel returns row_value and status, one response per request, in order.
// Commands: load a row, advance one generation, read a row. A load or read of a
// row at or beyond the grid side gives status 1 and changes nothing.
// cfg_wr_en / cfg_wr_data set the grid side; write it only while idle.
// A load, read or unused command goes from the request transfer to ST_FINISH,
// which loads the result register. A generation step fetches row 0, then the
// last row, then passes one row per cycle through the row memory (one read two
// rows ahead and one write of the current row per cycle), then loads the
// result in ST_FINISH. One request is in flight at a time; the next transfer
// is taken in the cycle after the result is loaded.
// The result sits in an output register; when the receiver stalls, the block
// finishes the item and holds in its last state until the register frees.
// Reset clears the grid to all dead through per-row valid bits at once, so
// requests are taken right after reset; the side resets to 64.
`include "life_automaton_torus_step_core_assert.svh"

module life_automaton_torus_step_core #(
    parameter int MAX_SIDE = lat_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lat_pkg::SIZE_W-1:0] cfg_wr_data,
    lat_req_if.sink                    request,
    lat_rsp_if.source                  response
);
    import lat_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t dp_status;

    // sequencer
    lat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .dp_status (dp_status),
        .ctl       (ctl)
    );

    // grid memory and row logic
    lat_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_command    (request.command),
        .in_row_number (request.row_number),
        .in_row_cells  (request.row_cells),
        .ctl           (ctl),
        .dp_status     (dp_status),
        .out_valid     (response.valid),
        .out_ready     (response.ready),
        .out_row_value (response.row_value),
        .out_status    (response.status)
    );

    // checks
    `LAT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, request.valid && request.ready, !request.ready)
    `LAT_ASSERT_IMPL(a_result_slot_free, clk, rst_n, ctl.result_load, dp_status.out_free)
    `LAT_ASSERT_IMPL(a_oob_zero_value, clk, rst_n, response.valid && response.status,
                     response.row_value == '0)
endmodule

// ----- tb/life_automaton_torus_step_core_test.sv -----
`timescale 1ns / 100ps

module life_automaton_torus_step_core_test;
    import lat_pkg::*;

    localparam int MAX_ROWS = MAX_SIDE_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 1220;
    localparam int MAX_GAP = 12;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [ROW_W-1:0] row_value;
        logic             status;
    } row_reply_t;

    // grid predictor and in-order reply checker
    class life_scoreboard;
        logic [ROW_W-1:0]  grid [MAX_ROWS];
        logic [SIZE_W-1:0] side_reg;
        row_reply_t        expected_replies [$];
        int failures;
        int loads;
        int steps;
        int reads;
        int unused_cmds;
        int outside_rows;
        int replies_checked;

        function new();
            for (int r = 0; r < MAX_ROWS; r++)
                grid[r] = '0;
            side_reg = GRID_SIZE_RESET;
        endfunction

        function void set_side(logic [SIZE_W-1:0] value);
            side_reg = value;
        endfunction

        // side clamped to the supported range
        function int side_in_use();
            int n;
            n = int'(side_reg);
            if (n < int'(MIN_SIDE))
                n = int'(MIN_SIDE);
            if (n > MAX_ROWS)
                n = MAX_ROWS;
            return n;
        endfunction

        function logic [ROW_W-1:0] column_mask(int n);
            if (n >= ROW_W)
                return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        // one generation over the rows in use, wrapping at every edge
        function void advance_torus();
            logic [ROW_W-1:0] old_rows [MAX_ROWS];
            logic [ROW_W-1:0] mask;
            logic [ROW_W-1:0] fresh;
            int n;
            int count;
            n = side_in_use();
            mask = column_mask(n);
            for (int r = 0; r < n; r++)
                old_rows[r] = grid[r] & mask;
            for (int r = 0; r < n; r++)
            begin
                fresh = '0;
                for (int j = 0; j < n; j++)
                begin
                    count = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0)
                                count += int'(old_rows[(r + dr + n) % n][(j + dc + n) % n]);
                    if (count == int'(BIRTH_COUNT)
                        || (old_rows[r][j] && count == int'(SURVIVE_COUNT)))
                        fresh[j] = 1'b1;
                end
                grid[r] = fresh;
            end
        endfunction

        // accepted request: update the grid and queue its reply
        function void note_request(logic [CMD_W-1:0] cmd, logic [ROW_NUM_W-1:0] row,
                                   logic [ROW_W-1:0] cells);
            row_reply_t reply;
            int n;
            logic [ROW_W-1:0] mask;
            n = side_in_use();
            mask = column_mask(n);
            reply = '0;
            case (cmd)
                CMD_STEP:
                begin
                    advance_torus();
                    steps++;
                end
                CMD_LOAD, CMD_READ:
                begin
                    if (cmd == CMD_LOAD)
                        loads++;
                    else
                        reads++;
                    if (int'(row) >= n)
                    begin
                        reply.status = 1'b1;
                        outside_rows++;
                    end
                    else if (cmd == CMD_LOAD)
                        grid[row] = cells & mask;
                    else
                        reply.row_value = grid[row] & mask;
                end
                default:
                    unused_cmds++;
            endcase
            expected_replies.push_back(reply);
        endfunction

        function void report(string what, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        endfunction

        // accepted response against the oldest expectation
        function void check_response(logic [ROW_W-1:0] value, logic st);
            row_reply_t want;
            if (expected_replies.size() == 0)
            begin
                report("unexpected response", '0, value);
                return;
            end
            want = expected_replies.pop_front();
            replies_checked++;
            if (value !== want.row_value)
                report("row_value", want.row_value, value);
            if (st !== want.status)
                report("status", 64'(want.status), 64'(st));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    lat_req_if request_bus ();
    lat_rsp_if response_bus ();

    life_scoreboard sb;
    int items_sent;
    int side_writes;
    int sender_gap_max;
    int receiver_gap_max;
    logic hold_response;

    life_automaton_torus_step_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request_bus),
        .response    (response_bus)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("run timed out");
        $display("simulation failed");
        $finish;
    end

    // transfer monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_bus.valid && request_bus.ready)
                sb.note_request(request_bus.command, request_bus.row_number,
                                request_bus.row_cells);
            if (response_bus.valid && response_bus.ready)
                sb.check_response(response_bus.row_value, response_bus.status);
        end
    end

    // response receiver with random stalls
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = $urandom_range(0, receiver_gap_max);
            @(negedge clk);
            if (gap > 0 || hold_response)
            begin
                response_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                while (hold_response)
                    @(negedge clk);
            end
            response_bus.ready <= 1'b1;
            @(posedge clk);
            while (!response_bus.valid)
                @(posedge clk);
        end
    end

    // long receiver stall while requests keep coming
    initial
    begin
        hold_response = 1'b0;
        wait (items_sent >= 400);
        @(posedge clk);
        hold_response = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_response = 1'b0;
    end

    function automatic logic [ROW_W-1:0] random_cells(int density);
        logic [ROW_W-1:0] cells;
        cells = {$urandom, $urandom};
        for (int k = 0; k < density; k++)
            cells &= {$urandom, $urandom};
        return cells;
    endfunction

    // offer one request and wait for its transfer
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ROW_NUM_W-1:0] row,
                                input logic [ROW_W-1:0] cells);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            request_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_bus.valid      <= 1'b1;
        request_bus.command    <= cmd;
        request_bus.row_number <= row;
        request_bus.row_cells  <= cells;
        @(posedge clk);
        while (!request_bus.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // occasionally slip in a random request before the intended one
    task automatic send_with_noise(input logic [CMD_W-1:0] cmd,
                                   input logic [ROW_NUM_W-1:0] row,
                                   input logic [ROW_W-1:0] cells);
        if ($urandom_range(0, 7) == 0)
            send_request(CMD_W'($urandom_range(0, 3)), ROW_NUM_W'($urandom_range(0, 63)),
                         {$urandom, $urandom});
        send_request(cmd, row, cells);
    endtask

    // drop valid and wait until every reply has come back
    task automatic settle();
        @(negedge clk);
        request_bus.valid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_side(input logic [SIZE_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_side(value);
        side_writes++;
    endtask

    // one side setting: fill the grid, then rounds of generations and full reads
    task automatic run_phase();
        logic [SIZE_W-1:0] side_value;
        int n;
        int density;
        int rounds;
        case ($urandom_range(0, 9))
            0: side_value = SIZE_W'($urandom_range(0, 2));
            1: side_value = MIN_SIDE;
            2: side_value = SIZE_W'(MAX_ROWS);
            3: side_value = SIZE_W'($urandom_range(65, 127));
            4: side_value = SIZE_W'($urandom_range(17, 63));
            default: side_value = SIZE_W'($urandom_range(4, 16));
        endcase
        write_side(side_value);
        n = sb.side_in_use();
        sender_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        receiver_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        density = $urandom_range(0, 2);
        // sometimes keep the old grid so rows from a larger side show through
        if ($urandom_range(0, 3) != 0)
            for (int r = 0; r < n; r++)
                send_with_noise(CMD_LOAD, ROW_NUM_W'(r), random_cells(density));
        rounds = $urandom_range(1, 4);
        for (int k = 0; k < rounds; k++)
        begin
            repeat ($urandom_range(1, 3))
                send_with_noise(CMD_STEP, ROW_NUM_W'($urandom_range(0, 63)),
                                {$urandom, $urandom});
            for (int r = 0; r < n; r++)
                send_with_noise(CMD_READ, ROW_NUM_W'(r), {$urandom, $urandom});
        end
    endtask

    // stimulus
    initial
    begin
        sb = new();
        items_sent       = 0;
        side_writes      = 0;
        sender_gap_max   = MAX_GAP;
        receiver_gap_max = MAX_GAP;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        request_bus.valid      = 1'b0;
        request_bus.command    = CMD_LOAD;
        request_bus.row_number = '0;
        request_bus.row_cells  = '0;
        response_bus.ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full side after reset: extremes of the row fields, unused command
        send_request(CMD_READ, 6'd0, '0);
        send_request(CMD_LOAD, 6'd0, '1);
        send_request(CMD_LOAD, 6'd63, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(CMD_LOAD, 6'd62, 64'h5555_5555_5555_5555);
        send_request(CMD_READ, 6'd63, '0);
        send_request(CMD_READ, 6'd0, '1);
        send_request(CMD_UNUSED, 6'd63, '1);
        send_request(CMD_STEP, 6'd63, '1);
        send_request(CMD_READ, 6'd0, '0);
        send_request(CMD_READ, 6'd63, '0);
        send_request(CMD_READ, 6'd1, '0);

        // side below range acts as the minimum; bits and rows beyond it
        write_side('0);
        send_request(CMD_LOAD, 6'd2, '1);
        send_request(CMD_READ, 6'd2, '0);
        send_request(CMD_LOAD, 6'd3, '1);
        send_request(CMD_READ, 6'd63, '0);
        send_request(CMD_STEP, 6'd0, '0);
        send_request(CMD_READ, 6'd0, '0);
        send_request(CMD_READ, 6'd1, '0);
        send_request(CMD_READ, 6'd2, '0);

        // side above range acts as the maximum; untouched rows come back
        write_side('1);
        send_request(CMD_READ, 6'd63, '0);
        send_request(CMD_READ, 6'd3, '0);

        while (items_sent < TOTAL_ITEMS)
            run_phase();

        settle();
        repeat (80) @(posedge clk);
        $display("covered %0d requests: %0d loads, %0d generation steps, %0d reads, %0d unused",
                 items_sent, sb.loads, sb.steps, sb.reads, sb.unused_cmds);
        $display("%0d rows outside the grid, %0d side writes, %0d responses checked",
                 sb.outside_rows, side_writes, sb.replies_checked);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
